/* hw/rtl/sfls_pkg.sv */
// Package with the types, codes and constants of the serial flash log sequencer.
package sfls_pkg;

  localparam int unsigned EntryBytes  = 16;
  localparam int unsigned EntryAw     = $clog2(EntryBytes);
  localparam int unsigned LineW       = 11;
  localparam int unsigned Log2Size    = 4;
  localparam int unsigned CmdDepth    = 8;
  localparam int unsigned CmdAw       = $clog2(CmdDepth);

  localparam logic [LineW-1:0] AppendAddrStart = LineW'(16);

  localparam logic [7:0] CmdStatus   = 8'hd7;
  localparam logic [7:0] StatusReady = 8'h80;
  localparam logic [7:0] CmdPageRead = 8'hd2;
  localparam logic [7:0] CmdProgram  = 8'h82;
  localparam logic [7:0] CmdToBuffer = 8'h53;
  localparam logic [7:0] PageMask    = 8'hfe;

  typedef enum logic [2:0] {
    REQ_READ     = 3'd0,
    REQ_WRITE    = 3'd1,
    REQ_APPEND   = 3'd2,
    REQ_BYTE     = 3'd3,
    REQ_DISABLED = 3'd4,
    REQ_LOAD     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_BUFFER = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_WAITING = 3'd0,
    PH_STATUS  = 3'd1,
    PH_SEND    = 3'd2,
    PH_EXEC    = 3'd3,
    PH_FAILED  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [LineW-1:0] line;
    logic [7:0]       rx_byte;
    logic             spi_ready;
    logic [3:0]       entry_index;
    logic [7:0]       entry_byte;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       spi_send_valid;
    logic [7:0] spi_byte;
    logic       select_release;
    logic       select_assert;
    logic       disable_request;
    logic       read_valid;
    logic [3:0] read_index;
    logic [7:0] read_value;
    logic       read_done;
    logic       append_done;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [EntryAw-1:0] addr;
    logic [7:0]         data;
  } ent_wr_t;

  // Low address byte of a line.
  function automatic logic [7:0] addr_lo(input logic [LineW-1:0] ln);
    addr_lo = {ln[3:0], 4'b0000};
  endfunction

  // Middle address byte of a line, page aligned.
  function automatic logic [7:0] addr_mid(input logic [LineW-1:0] ln);
    addr_mid = ln[10:3] & PageMask;
  endfunction

endpackage

/* hw/rtl/sfls_req_if.sv */
// Request channel interface carrying one input item.
interface sfls_req_if;
  logic           valid;
  logic           ready;
  sfls_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/sfls_rsp_if.sv */
// Response channel interface carrying one result item.
interface sfls_rsp_if;
  logic           valid;
  logic           ready;
  sfls_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/sfls_cfg_if.sv */
// Configuration write channel interface for the append start line register.
interface sfls_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/serial_flash_log_sequencer.sv */
// Top level of the serial flash log sequencer.
//
//   Channel  Direction  Handshake      Carries
//   req_i    in         valid/ready    one event or request per item
//   rsp_o    out        valid/ready    one response per item
//   cfg_i    in         valid/ready    append start line (always ready)
//
// One request is taken every cycle; its response is registered and leaves
// from a two-entry buffer. Requests stall only while both buffer entries
// hold responses. The write entry store reads ahead at the next data position,
// registering the byte before it is used, with forwarding of a same-cycle load.
// Reset needs no clearing pass.
module serial_flash_log_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfls_req_if.sink    req_i,
  sfls_rsp_if.source  rsp_o,
  sfls_cfg_if.sink    cfg_i
);
  import sfls_pkg::*;

  logic                 accept;
  logic                 full;
  ent_wr_t              ent_wr;
  logic [EntryAw-1:0]   ent_raddr;
  logic [7:0]           ent_rdata;
  rsp_t                 rsp;

  assign req_i.ready = !full;
  assign accept      = req_i.valid && !full;
  assign cfg_i.ready = 1'b1;

  sfls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (req_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .ent_rdata_i (ent_rdata),
    .ent_wr_o    (ent_wr),
    .ent_raddr_o (ent_raddr),
    .rsp_o       (rsp)
  );

  sfls_entry_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ent_wr),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  sfls_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (rsp),
    .full_o  (full),
    .valid_o (rsp_o.valid),
    .pop_i   (rsp_o.ready),
    .data_o  (rsp_o.data)
  );

endmodule

/* hw/rtl/sfls_entry_ram.sv */
// Write entry store: 16 by 8 synchronous memory with registered read and write forwarding.
module sfls_entry_ram (
  input  logic                              clk_i,
  input  sfls_pkg::ent_wr_t                 wr_i,
  input  logic [sfls_pkg::EntryAw-1:0]      raddr_i,
  output logic [7:0]                        rdata_o
);
  import sfls_pkg::*;

  logic [7:0] mem [EntryBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.addr == raddr_i)) begin
      rdata_q <= wr_i.data;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sfls_ctrl.sv */
// Sequencer state and per-item update that produces one response per request.
module sfls_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  sfls_pkg::req_t               item_i,
  input  logic                         cfg_we_i,
  input  logic [sfls_pkg::LineW-1:0]   cfg_data_i,
  input  logic [7:0]                   ent_rdata_i,
  output sfls_pkg::ent_wr_t            ent_wr_o,
  output logic [sfls_pkg::EntryAw-1:0] ent_raddr_o,
  output sfls_pkg::rsp_t               rsp_o
);
  import sfls_pkg::*;

  mode_e            mode_q, mode_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       cmd_q [CmdDepth];
  logic [7:0]       cmd_d [CmdDepth];
  logic [3:0]       cpos_q, cpos_d;
  logic [4:0]       dpos_q, dpos_d;
  logic             dis_q, dis_d;
  logic [LineW-1:0] last_q, last_d;
  logic             known_q, known_d;
  logic [LineW-1:0] start_q, start_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= PH_EXEC;
      for (int i = 0; i < CmdDepth; i++) begin
        cmd_q[i] <= 8'h00;
      end
      cpos_q  <= 4'hf;
      dpos_q  <= '0;
      dis_q   <= 1'b0;
      last_q  <= '0;
      known_q <= 1'b0;
      start_q <= AppendAddrStart;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      for (int i = 0; i < CmdDepth; i++) begin
        cmd_q[i] <= cmd_d[i];
      end
      cpos_q  <= cpos_d;
      dpos_q  <= dpos_d;
      dis_q   <= dis_d;
      last_q  <= last_d;
      known_q <= known_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    logic             do_status;
    logic             do_write;
    logic             same_page;
    logic [LineW-1:0] wline;
    logic [4:0]       dpos_inc;
    logic [3:0]       cpos_dec;

    mode_d    = mode_q;
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    cpos_d    = cpos_q;
    dpos_d    = dpos_q;
    dis_d     = dis_q;
    last_d    = last_q;
    known_d   = known_q;
    start_d   = cfg_we_i ? cfg_data_i : start_q;
    rsp_o     = '0;
    ent_wr_o  = '0;
    do_status = 1'b0;
    do_write  = 1'b0;
    same_page = 1'b0;
    wline     = known_q ? (last_q + LineW'(1)) : start_q;
    dpos_inc  = dpos_q + 5'd1;
    cpos_dec  = cpos_q - 4'd1;

    if (item_i.req_type == REQ_WRITE) begin
      wline = item_i.line;
    end

    if (accept_i) begin
      case (item_i.req_type)
        REQ_READ: begin
          if (mode_q == MODE_IDLE) begin
            mode_d    = MODE_READ;
            dpos_d    = '0;
            cmd_d[5]  = addr_lo(item_i.line);
            cmd_d[6]  = addr_mid(item_i.line);
            cmd_d[7]  = 8'h00;
            cpos_d    = 4'd7;
            do_status = 1'b1;
          end
        end
        REQ_WRITE, REQ_APPEND: begin
          if (mode_q == MODE_IDLE) begin
            same_page = known_q && (wline[LineW-1:Log2Size] == last_q[LineW-1:Log2Size]);
            last_d    = wline;
            known_d   = 1'b1;
            dpos_d    = '0;
            mode_d    = same_page ? MODE_WRITE : MODE_BUFFER;
            do_write  = 1'b1;
          end
        end
        REQ_BYTE: begin
          case (phase_q)
            PH_WAITING: begin
              phase_d               = PH_STATUS;
              rsp_o.spi_send_valid  = 1'b1;
            end
            PH_STATUS: begin
              if ((item_i.rx_byte & StatusReady) != 8'h00) begin
                phase_d = PH_SEND;
              end
              dis_d                 = 1'b1;
              rsp_o.disable_request = 1'b1;
            end
            PH_SEND: begin
              rsp_o.spi_send_valid = 1'b1;
              rsp_o.spi_byte       = cmd_q[cpos_q[CmdAw-1:0]];
              cpos_d               = cpos_dec;
              if (cpos_dec[3]) begin
                phase_d = PH_EXEC;
              end
            end
            PH_EXEC: begin
              if (mode_q == MODE_READ) begin
                rsp_o.read_valid = 1'b1;
                rsp_o.read_index = dpos_q[3:0];
                rsp_o.read_value = item_i.rx_byte;
                dpos_d           = dpos_inc;
                if (dpos_inc < 5'(EntryBytes)) begin
                  rsp_o.spi_send_valid = 1'b1;
                end else begin
                  dis_d                 = 1'b1;
                  rsp_o.disable_request = 1'b1;
                end
              end else if ((mode_q == MODE_WRITE) && (dpos_q < 5'(EntryBytes))) begin
                rsp_o.spi_send_valid = 1'b1;
                rsp_o.spi_byte       = ent_rdata_i;
                dpos_d               = dpos_inc;
              end else begin
                dis_d                 = 1'b1;
                rsp_o.disable_request = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        REQ_DISABLED: begin
          if (dis_q) begin
            dis_d                = 1'b0;
            rsp_o.select_release = 1'b1;
            case (phase_q)
              PH_STATUS: begin
                do_status = 1'b1;
              end
              PH_SEND: begin
                rsp_o.select_assert  = 1'b1;
                rsp_o.spi_send_valid = 1'b1;
                case (mode_q)
                  MODE_READ:   rsp_o.spi_byte = CmdPageRead;
                  MODE_WRITE:  rsp_o.spi_byte = CmdProgram;
                  MODE_BUFFER: rsp_o.spi_byte = CmdToBuffer;
                  default:     rsp_o.spi_byte = 8'h00;
                endcase
              end
              PH_EXEC: begin
                if (mode_q == MODE_READ) begin
                  rsp_o.read_done = 1'b1;
                  mode_d          = MODE_IDLE;
                end else if (mode_q == MODE_WRITE) begin
                  rsp_o.append_done = 1'b1;
                  mode_d            = MODE_IDLE;
                end else if (mode_q == MODE_BUFFER) begin
                  wline    = last_q;
                  mode_d   = MODE_WRITE;
                  do_write = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        REQ_LOAD: begin
          ent_wr_o.we   = 1'b1;
          ent_wr_o.addr = item_i.entry_index;
          ent_wr_o.data = item_i.entry_byte;
        end
        default: begin
        end
      endcase

      if (do_write) begin
        cmd_d[0]  = addr_lo(wline);
        cmd_d[1]  = addr_mid(wline);
        cmd_d[2]  = 8'h00;
        cpos_d    = 4'd2;
        do_status = 1'b1;
      end

      if (do_status) begin
        rsp_o.select_assert = 1'b1;
        if (item_i.spi_ready) begin
          phase_d              = PH_WAITING;
          rsp_o.spi_send_valid = 1'b1;
          rsp_o.spi_byte       = CmdStatus;
          rsp_o.accepted       = (item_i.req_type != REQ_DISABLED);
        end else begin
          phase_d               = PH_FAILED;
          dis_d                 = 1'b1;
          rsp_o.disable_request = 1'b1;
        end
      end
    end
  end

  assign ent_raddr_o = dpos_d[EntryAw-1:0];

endmodule

/* hw/rtl/sfls_out_buf.sv */
// Two-entry response buffer that decouples the request side from the response side.
module sfls_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfls_pkg::rsp_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sfls_pkg::rsp_t data_o
);
  import sfls_pkg::*;

  rsp_t       buf_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the serial flash log sequencer with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import sfls_pkg::*;

  typedef struct packed {
    mode_e                      mode;
    phase_e                     phase;
    logic [CmdDepth-1:0][7:0]   cmd;
    logic [3:0]                 cmd_pos;
    logic [4:0]                 data_pos;
    logic                       dis_pend;
    logic [LineW-1:0]           prev_line;
    logic                       last_known;
    logic [EntryBytes-1:0][7:0] entry;
    logic [LineW-1:0]           start_line;
  } seq_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  req_t req_data = '0;
  logic rsp_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [LineW-1:0] cfg_data = '0;
  logic hold_rsp = 1'b0;

  seq_state_t live_seq;
  seq_state_t plan_seq;
  req_t event_q[$];
  rsp_t rsp_expect_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_reads_done = 0;
  int n_writes_done = 0;

  sfls_req_if req_if ();
  sfls_rsp_if rsp_if ();
  sfls_cfg_if cfg_if ();

  assign req_if.valid = req_valid;
  assign req_if.data  = req_data;
  assign rsp_if.ready = rsp_ready;
  assign cfg_if.valid = cfg_valid;
  assign cfg_if.data  = cfg_data;

  serial_flash_log_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic seq_state_t reset_seq();
    seq_state_t s;
    s = '0;
    s.mode = MODE_IDLE;
    s.phase = PH_EXEC;
    s.cmd_pos = 4'hf;
    s.start_line = AppendAddrStart;
    return s;
  endfunction

  function automatic void load_address(inout seq_state_t s, input logic [LineW-1:0] ln,
                                       input logic [2:0] base);
    s.cmd[base] = 8'(ln << Log2Size);
    s.cmd[3'(base + 3'd1)] = 8'(ln >> (7 - Log2Size)) & PageMask;
    s.cmd[3'(base + 3'd2)] = 8'(ln >> (15 - Log2Size));
  endfunction

  function automatic logic open_status(inout seq_state_t s, input logic ready,
                                       inout rsp_t o);
    s.phase = PH_WAITING;
    o.select_assert = 1'b1;
    if (ready) begin
      o.spi_send_valid = 1'b1;
      o.spi_byte = CmdStatus;
      return 1'b1;
    end
    s.phase = PH_FAILED;
    s.dis_pend = 1'b1;
    o.disable_request = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic start_program(inout seq_state_t s, input mode_e mode,
                                         input logic ready, inout rsp_t o);
    load_address(s, s.prev_line, 3'd0);
    s.mode = mode;
    s.cmd_pos = 4'd2;
    return open_status(s, ready, o);
  endfunction

  function automatic logic claim_line(inout seq_state_t s, input logic [LineW-1:0] ln,
                                      input logic ready, inout rsp_t o);
    logic same_page;
    if (s.mode != MODE_IDLE) return 1'b0;
    same_page = s.last_known && (ln[LineW-1:Log2Size] == s.prev_line[LineW-1:Log2Size]);
    s.prev_line = ln;
    s.last_known = 1'b1;
    s.data_pos = '0;
    return start_program(s, same_page ? MODE_WRITE : MODE_BUFFER, ready, o);
  endfunction

  function automatic void shift_done(inout seq_state_t s, input logic [7:0] rx,
                                     inout rsp_t o);
    logic finish_up;
    finish_up = 1'b1;
    case (s.phase)
      PH_WAITING: begin
        s.phase = PH_STATUS;
        o.spi_send_valid = 1'b1;
        o.spi_byte = 8'h00;
      end
      PH_STATUS: begin
        if ((rx & StatusReady) != 8'h00) s.phase = PH_SEND;
        s.dis_pend = 1'b1;
        o.disable_request = 1'b1;
      end
      PH_SEND: begin
        o.spi_send_valid = 1'b1;
        o.spi_byte = s.cmd[s.cmd_pos[2:0]];
        s.cmd_pos = s.cmd_pos - 4'd1;
        if (s.cmd_pos[3]) s.phase = PH_EXEC;
      end
      PH_EXEC: begin
        if (s.mode == MODE_READ) begin
          o.read_valid = 1'b1;
          o.read_index = s.data_pos[3:0];
          o.read_value = rx;
          s.data_pos = s.data_pos + 5'd1;
          if (s.data_pos < EntryBytes) begin
            o.spi_send_valid = 1'b1;
            o.spi_byte = 8'h00;
            finish_up = 1'b0;
          end
        end else if (s.mode == MODE_WRITE && s.data_pos < EntryBytes) begin
          o.spi_send_valid = 1'b1;
          o.spi_byte = s.entry[s.data_pos[3:0]];
          s.data_pos = s.data_pos + 5'd1;
          finish_up = 1'b0;
        end
        if (finish_up) begin
          s.dis_pend = 1'b1;
          o.disable_request = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flash_off(inout seq_state_t s, input logic ready, inout rsp_t o);
    if (!s.dis_pend) return;
    s.dis_pend = 1'b0;
    o.select_release = 1'b1;
    case (s.phase)
      PH_STATUS: void'(open_status(s, ready, o));
      PH_SEND: begin
        o.select_assert = 1'b1;
        o.spi_send_valid = 1'b1;
        case (s.mode)
          MODE_READ:   o.spi_byte = CmdPageRead;
          MODE_WRITE:  o.spi_byte = CmdProgram;
          MODE_BUFFER: o.spi_byte = CmdToBuffer;
          default:     o.spi_byte = 8'h00;
        endcase
      end
      PH_EXEC: begin
        if (s.mode == MODE_READ) begin
          o.read_done = 1'b1;
          s.mode = MODE_IDLE;
        end else if (s.mode == MODE_WRITE) begin
          o.append_done = 1'b1;
          s.mode = MODE_IDLE;
        end else if (s.mode == MODE_BUFFER) begin
          void'(start_program(s, MODE_WRITE, ready, o));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic rsp_t seq_step(inout seq_state_t s, input req_t r);
    rsp_t o;
    logic ok;
    logic [LineW-1:0] target;
    o = '0;
    case (r.req_type)
      REQ_READ: begin
        if (s.mode == MODE_IDLE) begin
          s.mode = MODE_READ;
          s.data_pos = '0;
          load_address(s, r.line, 3'd5);
          s.cmd_pos = 4'd7;
          ok = open_status(s, r.spi_ready, o);
          o.accepted = ok;
        end
      end
      REQ_WRITE: begin
        ok = claim_line(s, r.line, r.spi_ready, o);
        o.accepted = ok;
      end
      REQ_APPEND: begin
        target = s.last_known ? s.prev_line + 11'd1 : s.start_line;
        ok = claim_line(s, target, r.spi_ready, o);
        o.accepted = ok;
      end
      REQ_BYTE:     shift_done(s, r.rx_byte, o);
      REQ_DISABLED: flash_off(s, r.spi_ready, o);
      REQ_LOAD:     s.entry[r.entry_index] = r.entry_byte;
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t make_req(input logic [2:0] kind);
    req_t r;
    r.req_type = kind;
    r.line = 11'($urandom);
    r.rx_byte = 8'($urandom);
    r.spi_ready = 1'($urandom);
    r.entry_index = 4'($urandom);
    r.entry_byte = 8'($urandom);
    return r;
  endfunction

  function automatic logic [LineW-1:0] pick_line(input seq_state_t p);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return {p.prev_line[LineW-1:Log2Size], 4'($urandom)};
    if (roll < 35) return '0;
    if (roll < 45) return '1;
    return 11'($urandom);
  endfunction

  function automatic req_t pick_event(input seq_state_t p);
    req_t r;
    int unsigned roll;
    roll = $urandom_range(99);
    r = make_req(3'($urandom));
    if (roll < 10) return r;
    if (p.dis_pend) begin
      r.req_type = REQ_DISABLED;
    end else if (p.mode == MODE_IDLE) begin
      if (roll < 20) begin
        r.req_type = REQ_LOAD;
      end else if (roll < 25) begin
        r.req_type = REQ_BYTE;
      end else begin
        if (p.last_known && p.prev_line == '1 && $urandom_range(9) < 7) begin
          r.req_type = REQ_APPEND;
        end else begin
          case ($urandom_range(2))
            0:       r.req_type = REQ_READ;
            1:       r.req_type = REQ_WRITE;
            default: r.req_type = REQ_APPEND;
          endcase
        end
        r.line = pick_line(p);
      end
    end else if (roll < 15) begin
      r.req_type = REQ_LOAD;
    end else begin
      r.req_type = REQ_BYTE;
      if (p.phase == PH_STATUS) r.rx_byte[7] = ($urandom_range(99) < 85);
    end
    return r;
  endfunction

  // Steps the planning copy and keeps the status command from being refused unless allowed.
  function automatic bit queue_event(input req_t r, input bit may_fail);
    seq_state_t trial;
    rsp_t res;
    trial = plan_seq;
    void'(seq_step(trial, r));
    if (!may_fail && trial.phase == PH_FAILED && plan_seq.phase != PH_FAILED)
      r.spi_ready = 1'b1;
    res = seq_step(plan_seq, r);
    event_q.push_back(r);
    return (res != '0) || (r.req_type == REQ_LOAD);
  endfunction

  function automatic string rsp_text(input rsp_t r);
    return $sformatf("acc=%b tx=%b/%h rel=%b sel=%b dis=%b rd=%b/%h/%h rdone=%b wdone=%b",
                     r.accepted, r.spi_send_valid, r.spi_byte, r.select_release,
                     r.select_assert, r.disable_request, r.read_valid, r.read_index,
                     r.read_value, r.read_done, r.append_done);
  endfunction

  task automatic set_start_line(input logic [LineW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_valid <= 1'b0;
    live_seq.start_line = v;
    plan_seq.start_line = v;
  endtask

  task automatic wait_drained();
    while (event_q.size() != 0 || req_valid || rsp_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic directed_events();
    req_t r;
    for (int i = 0; i < EntryBytes; i++) begin
      r = make_req(REQ_LOAD);
      r.entry_index = 4'(i);
      r.entry_byte = (i == 0) ? 8'h00 : (i == EntryBytes - 1) ? 8'hff : 8'($urandom);
      void'(queue_event(r, 1'b0));
    end
    r = make_req(REQ_BYTE);
    r.rx_byte = 8'hff;
    void'(queue_event(r, 1'b0));
    void'(queue_event(make_req(REQ_DISABLED), 1'b0));
    void'(queue_event(make_req(REQ_DISABLED), 1'b0));
    void'(queue_event(make_req(3'd6), 1'b0));
    void'(queue_event(make_req(3'd7), 1'b0));
    void'(queue_event(make_req(REQ_APPEND), 1'b0));
  endtask

  task automatic random_events(input int count);
    int n_done;
    n_done = 0;
    while (n_done < count)
      if (queue_event(pick_event(plan_seq), 1'b0)) n_done++;
  endtask

  // Finishes the open sequence, then lets a refused status command lock the block up.
  task automatic closing_events();
    req_t r;
    int guard;
    guard = 0;
    while ((plan_seq.mode != MODE_IDLE || plan_seq.dis_pend) && guard < 400) begin
      void'(queue_event(pick_event(plan_seq), 1'b0));
      guard++;
    end
    r = make_req(REQ_WRITE);
    r.spi_ready = 1'b0;
    void'(queue_event(r, 1'b1));
    void'(queue_event(make_req(REQ_BYTE), 1'b1));
    void'(queue_event(make_req(REQ_DISABLED), 1'b1));
    for (int i = 0; i < 30; i++) void'(queue_event(pick_event(plan_seq), 1'b1));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_valid && req_if.ready) begin
        rsp_expect_q.push_back(seq_step(live_seq, req_data));
        n_sent++;
      end
      if (!req_valid || req_if.ready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_data <= event_q.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rsp_if.valid && rsp_ready) begin
      n_checked++;
      if (rsp_expect_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected response %0d: %s", n_checked, rsp_text(rsp_if.data));
      end else begin
        want = rsp_expect_q.pop_front();
        if (rsp_if.data !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch on response %0d: expected %s, got %s", n_checked,
                     rsp_text(want), rsp_text(rsp_if.data));
        end
        if (want.read_done) n_reads_done++;
        if (want.append_done) n_writes_done++;
      end
    end
    rsp_ready <= rst_n && !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (n_sent >= 60);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    live_seq = reset_seq();
    plan_seq = reset_seq();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_start_line('1);
          directed_events();
          random_events(250);
        end
        1: begin
          send_idle_pct = 81;
          recv_stall_pct = 0;
          set_start_line('0);
          random_events(250);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 81;
          set_start_line(11'($urandom));
          random_events(250);
        end
        3: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
          set_start_line('1);
          random_events(250);
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
          set_start_line('0);
          closing_events();
        end
      endcase
      wait_drained();
      repeat (10) @(posedge clk);
    end
    $display("summary: %0d requests over five idling phases, %0d responses checked, %0d reads",
             n_sent, n_checked, n_reads_done);
    $display("summary: %0d line writes done, long output hold-off, refused status at the end",
             n_writes_done);
    if (n_mismatch == 0 && rsp_expect_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d responses still expected", rsp_expect_q.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* serial_flash_log_sequencer.f */
hw/rtl/sfls_pkg.sv
hw/rtl/sfls_req_if.sv
hw/rtl/sfls_rsp_if.sv
hw/rtl/sfls_cfg_if.sv
hw/rtl/sfls_entry_ram.sv
hw/rtl/sfls_ctrl.sv
hw/rtl/sfls_out_buf.sv
hw/rtl/serial_flash_log_sequencer.sv
verif/testbench.sv
